// ===== design/lppd_pkg.sv =====
// ----------------------------------------------------------------------------
// lppd_pkg
// Shared types and constants for the length-prefixed packet deframer.
// ----------------------------------------------------------------------------
package lppd_pkg;

	// Header layout: 16-bit type then 32-bit length, little endian
	localparam int unsigned HDR_BYTES = 6;
	localparam logic [2:0] HPOS_LAST = 3'(HDR_BYTES - 1);

	// Reset value of the payload limit register
	localparam logic [31:0] MAX_PAYLOAD_RESET = 32'd1048576;

	// Parser phase
	typedef enum logic [1:0] {
		PH_HEADER = 2'd0,
		PH_DATA   = 2'd1,
		PH_ERROR  = 2'd2
	} phase_t;

	// Event codes on the result channel
	typedef enum logic [1:0] {
		KIND_DATA  = 2'd0,
		KIND_EMPTY = 2'd1,
		KIND_ERROR = 2'd2
	} kind_t;

	// One result word from parser to output register
	typedef struct packed {
		kind_t       kind;
		logic [15:0] ftype;
		logic [7:0]  pbyte;
		logic [31:0] flen;
		logic        last;
	} res_t;

endpackage

// ===== design/lppd_if.sv =====
// ----------------------------------------------------------------------------
// lppd_if
// Valid/ready channels of the deframer: received bytes in, events out.
// ----------------------------------------------------------------------------
interface lppd_rx_if;
	logic       valid;
	logic       ready;
	logic [7:0] rx_byte;

	modport source (output valid, output rx_byte, input ready);
	modport sink (input valid, input rx_byte, output ready);
endinterface

interface lppd_ev_if;
	logic        valid;
	logic        ready;
	logic [1:0]  event_kind;
	logic [15:0] frame_type;
	logic [7:0]  payload_byte;
	logic [31:0] frame_length;
	logic        last_of_frame;

	modport source (output valid, output event_kind, output frame_type,
		output payload_byte, output frame_length, output last_of_frame, input ready);
	modport sink (input valid, input event_kind, input frame_type,
		input payload_byte, input frame_length, input last_of_frame, output ready);
endinterface

// ===== design/lppd_in_reg.sv =====
// ----------------------------------------------------------------------------
// lppd_in_reg
// Input register: holds one received byte until the parser takes it.
// ----------------------------------------------------------------------------
module lppd_in_reg (
	input  logic       clk,
	input  logic       arst_n,
	lppd_rx_if.sink    rx,
	input  logic       adv,
	output logic       valid_s1,
	output logic [7:0] byte_s1
);

	// Take a word whenever the stage is empty or being drained
	assign rx.ready = !valid_s1 || adv;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (rx.ready) begin
			valid_s1 <= rx.valid;
		end
	end

	always_ff @(posedge clk) begin
		if (rx.ready && rx.valid) begin
			byte_s1 <= rx.rx_byte;
		end
	end

endmodule

// ===== design/lppd_parse.sv =====
// ----------------------------------------------------------------------------
// lppd_parse
// Frame parser: header assembly, size check, payload countdown and limit
// register. Produces at most one result per byte taken.
// ----------------------------------------------------------------------------
module lppd_parse (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               cfg_we,
	input  logic [31:0]        cfg_wdata,
	input  logic               take,
	input  logic [7:0]         byte_s1,
	output logic               res_vld,
	output lppd_pkg::res_t     res
);

	lppd_pkg::phase_t phase_q, phase_d;
	logic [2:0]  hpos_q, hpos_d;
	logic [15:0] type_q, type_d;
	logic [31:0] len_q, len_d;
	logic [31:0] rem_q, rem_d;
	logic [31:0] max_q;

	// Payload limit register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			max_q <= lppd_pkg::MAX_PAYLOAD_RESET;
		end else if (cfg_we) begin
			max_q <= cfg_wdata;
		end
	end

	// Parser state
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			phase_q <= lppd_pkg::PH_HEADER;
			hpos_q  <= '0;
			type_q  <= '0;
			len_q   <= '0;
			rem_q   <= '0;
		end else if (take) begin
			phase_q <= phase_d;
			hpos_q  <= hpos_d;
			type_q  <= type_d;
			len_q   <= len_d;
			rem_q   <= rem_d;
		end
	end

	// Next state and result
	always_comb begin
		phase_d   = phase_q;
		hpos_d    = hpos_q;
		type_d    = type_q;
		len_d     = len_q;
		rem_d     = rem_q;
		res_vld   = 1'b0;
		res.kind  = lppd_pkg::KIND_DATA;
		res.pbyte = '0;
		res.last  = 1'b0;

		unique case (phase_q)
			lppd_pkg::PH_HEADER: begin
				// gather header bytes, low byte first
				unique case (hpos_q)
					3'd0: begin
						type_d = {8'd0, byte_s1};
						len_d  = '0;
					end
					3'd1: type_d = type_q | {byte_s1, 8'd0};
					3'd2: len_d  = {24'd0, byte_s1};
					3'd3: len_d  = len_q | {16'd0, byte_s1, 8'd0};
					3'd4: len_d  = len_q | {8'd0, byte_s1, 16'd0};
					default: len_d = len_q | {byte_s1, 24'd0};
				endcase
				hpos_d = hpos_q + 3'd1;
				if (hpos_q >= lppd_pkg::HPOS_LAST) begin
					hpos_d = '0;
					if (len_d >= max_q) begin
						phase_d  = lppd_pkg::PH_ERROR;
						res_vld  = 1'b1;
						res.kind = lppd_pkg::KIND_ERROR;
					end else if (len_d == '0) begin
						res_vld  = 1'b1;
						res.kind = lppd_pkg::KIND_EMPTY;
						res.last = 1'b1;
					end else begin
						rem_d   = len_d;
						phase_d = lppd_pkg::PH_DATA;
					end
				end
			end
			lppd_pkg::PH_DATA: begin
				// pass payload through, mark the final byte
				rem_d     = rem_q - 32'd1;
				res_vld   = 1'b1;
				res.pbyte = byte_s1;
				res.last  = (rem_d == '0);
				if (rem_d == '0) begin
					phase_d = lppd_pkg::PH_HEADER;
				end
			end
			default: begin
				// error phase: drop everything until reset
			end
		endcase

		res.ftype = type_d;
		res.flen  = len_d;
	end

endmodule

// ===== design/lppd_out_reg.sv =====
// ----------------------------------------------------------------------------
// lppd_out_reg
// Result register: holds one event word until the sink takes it.
// ----------------------------------------------------------------------------
module lppd_out_reg (
	input  logic           clk,
	input  logic           arst_n,
	input  logic           load,
	input  lppd_pkg::res_t res,
	output logic           free,
	lppd_ev_if.source      ev
);

	logic           valid_q;
	lppd_pkg::res_t res_q;

	// Slot can take a new word if empty or being emptied this cycle
	assign free = !valid_q || ev.ready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_q <= 1'b0;
		end else if (free) begin
			valid_q <= load;
		end
	end

	always_ff @(posedge clk) begin
		if (free && load) begin
			res_q <= res;
		end
	end

	assign ev.valid         = valid_q;
	assign ev.event_kind    = res_q.kind;
	assign ev.frame_type    = res_q.ftype;
	assign ev.payload_byte  = res_q.pbyte;
	assign ev.frame_length  = res_q.flen;
	assign ev.last_of_frame = res_q.last;

endmodule

// ===== design/length_prefixed_packet_deframer.sv =====
// ----------------------------------------------------------------------------
// length_prefixed_packet_deframer
// Splits a byte stream into type/length/value frames and emits one event
// per payload byte, per empty frame, or once on an oversize header.
// ----------------------------------------------------------------------------
// Channel   Dir   Handshake      Word
// rx        in    valid/ready    rx_byte[7:0]
// ev        out   valid/ready    event_kind, frame_type, payload_byte,
//                                frame_length, last_of_frame
// cfg       in    cfg_we         cfg_wdata[31:0] (payload limit; lengths >= it are errors)
//
// One byte per clock sustained while ev is ready; an accepted byte passes the
// input register, then the parser into the result register.
// Header bytes give no event; the sixth header byte and each payload byte
// give at most one. After an oversize header all bytes are dropped.
// A stalled event register holds the input register, which then holds rx.
// Reset clears the parser to header phase and the limit to 1048576.
// ----------------------------------------------------------------------------
module length_prefixed_packet_deframer (
	input  logic        clk,
	input  logic        arst_n,
	lppd_rx_if.sink     rx,
	lppd_ev_if.source   ev,
	input  logic        cfg_we,
	input  logic [31:0] cfg_wdata
);

	logic           valid_s1;
	logic [7:0]     byte_s1;
	logic           free;
	logic           take;
	logic           res_vld;
	lppd_pkg::res_t res;

	// Parser consumes a byte only when the result slot can accept
	assign take = valid_s1 && free;

	lppd_in_reg u_in (
		.clk      (clk),
		.arst_n   (arst_n),
		.rx       (rx),
		.adv      (take),
		.valid_s1 (valid_s1),
		.byte_s1  (byte_s1)
	);

	lppd_parse u_parse (
		.clk       (clk),
		.arst_n    (arst_n),
		.cfg_we    (cfg_we),
		.cfg_wdata (cfg_wdata),
		.take      (take),
		.byte_s1   (byte_s1),
		.res_vld   (res_vld),
		.res       (res)
	);

	lppd_out_reg u_out (
		.clk    (clk),
		.arst_n (arst_n),
		.load   (take && res_vld),
		.res    (res),
		.free   (free),
		.ev     (ev)
	);

`ifndef NO_ASSERTIONS
	// An accepted byte always lands in the input register
	a_rx_lands: assert property (@(posedge clk) disable iff (!arst_n)
		rx.valid && rx.ready |=> valid_s1)
		else $error("accepted byte not held in input register");

	// Error events never carry a last mark
	a_err_nolast: assert property (@(posedge clk) disable iff (!arst_n)
		ev.valid && (ev.event_kind == lppd_pkg::KIND_ERROR) |-> !ev.last_of_frame)
		else $error("error event with last mark");

	// Empty-frame events report zero length and close the frame
	a_empty_zero: assert property (@(posedge clk) disable iff (!arst_n)
		ev.valid && (ev.event_kind == lppd_pkg::KIND_EMPTY)
		|-> (ev.frame_length == '0) && ev.last_of_frame)
		else $error("empty frame event with nonzero length");
`endif

endmodule
